// ----- sv/ibfr_pkg.sv -----
// Shared types and constants for the serial RC frame receiver.
// No dependencies; used by ibfr_ctrl, ibfr_datapath and ibus_frame_receiver.
`default_nettype none

package ibfr_pkg;

  // Sync / length bytes
  localparam logic [7:0] SYNC_OLD  = 8'h55;
  localparam logic [7:0] LEN_NEW   = 8'd32;
  localparam logic [7:0] LEN_SHORT = 8'd4;
  localparam logic [5:0] LEN_OLD   = 6'd31;
  localparam logic [1:0] OFF_NEW   = 2'd2;
  localparam logic [1:0] OFF_OLD   = 2'd1;

  localparam logic [15:0] GAP_RESET = 16'd500;

  localparam int BUFFER_BYTES = 32;
  localparam int POS_W        = $clog2(BUFFER_BYTES);
  localparam int NUM_SLOTS    = 14;
  localparam int SLOT_AW      = $clog2(NUM_SLOTS);
  localparam int SLOT_DEPTH   = 1 << SLOT_AW;
  localparam int MAX_EXTRA    = 4;
  localparam int EXT_AW       = $clog2(MAX_EXTRA);
  localparam int CH_W         = 5;
  localparam int VAL_W        = 12;

  // Controller -> datapath
  typedef struct packed {
    logic take_byte;
    logic load;
    logic step;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic frame_emit;
    logic ch_last;
  } status_t;

  // Where a slot's high-byte nibble lands in the extra channels
  typedef struct packed {
    logic              hit;
    logic [EXT_AW-1:0] grp;
    logic [1:0]        part;
  } ext_place_t;

  function automatic ext_place_t ext_place(input logic [SLOT_AW-1:0] slot);
    ext_place_t p;
    p = '{hit: 1'b1, grp: '0, part: 2'd0};
    case (slot)
      4'd0:  begin p.grp = 2'd0; p.part = 2'd0; end
      4'd1:  begin p.grp = 2'd0; p.part = 2'd1; end
      4'd2:  begin p.grp = 2'd0; p.part = 2'd2; end
      4'd3:  begin p.grp = 2'd1; p.part = 2'd0; end
      4'd4:  begin p.grp = 2'd1; p.part = 2'd1; end
      4'd5:  begin p.grp = 2'd1; p.part = 2'd2; end
      4'd6:  begin p.grp = 2'd2; p.part = 2'd0; end
      4'd7:  begin p.grp = 2'd2; p.part = 2'd1; end
      4'd8:  begin p.grp = 2'd2; p.part = 2'd2; end
      4'd9:  begin p.grp = 2'd3; p.part = 2'd0; end
      4'd10: begin p.grp = 2'd3; p.part = 2'd1; end
      4'd11: begin p.grp = 2'd3; p.part = 2'd2; end
      default: p.hit = 1'b0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ibfr_ctrl.sv -----
// Sequencer for the frame receiver: byte intake, slot readout, channel emission.
// Depends on ibfr_pkg (cmd_t, status_t).
`default_nettype none

module ibfr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire ibfr_pkg::status_t status_i,
  output ibfr_pkg::cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOAD = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.frame_emit) state_d = ST_LOAD;
      end
      ST_LOAD: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_ready_i && status_i.ch_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_EMIT);
  assign cmd_o.take_byte = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.load      = (state_q == ST_LOAD);
  assign cmd_o.step      = (state_q == ST_EMIT) && out_ready_i;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("intake and emission active together");

  a_emit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && status_i.frame_emit) |=> !out_valid_o ##1 out_valid_o)
    else $error("good frame did not start emission after one load cycle");

  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && status_i.ch_last) |=> (in_ready_o && !out_valid_o))
    else $error("emission did not end after last channel");

  a_step_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> !cmd_o.take_byte && !cmd_o.load)
    else $error("channel step overlaps other commands");
`endif

endmodule

`default_nettype wire

// ----- sv/ibfr_datapath.sv -----
// Datapath: frame tracking, running checksum, slot word memory, extra channels.
// Depends on ibfr_pkg (constants, cmd_t, status_t, ext_place).
`default_nettype none

module ibfr_datapath #(
  parameter int NUM_CHANNELS = 18
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [15:0]                   cfg_wdata_i,
  input  wire logic [7:0]                    rx_byte_i,
  input  wire logic [31:0]                   now_us_i,
  input  wire ibfr_pkg::cmd_t                cmd_i,
  output ibfr_pkg::status_t                  status_o,
  output logic [ibfr_pkg::CH_W-1:0]          channel_index_o,
  output logic [ibfr_pkg::VAL_W-1:0]         channel_value_o,
  output logic [31:0]                        frame_time_us_o,
  output logic                               last_o
);

  localparam int POS_W   = ibfr_pkg::POS_W;
  localparam int SLOT_AW = ibfr_pkg::SLOT_AW;
  localparam int CH_W    = ibfr_pkg::CH_W;
  localparam int VAL_W   = ibfr_pkg::VAL_W;
  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);
  localparam logic [CH_W-1:0] SLOT_CH = CH_W'(ibfr_pkg::NUM_SLOTS);
  localparam logic [POS_W-1:0] DATA_BYTES = POS_W'(2 * ibfr_pkg::NUM_SLOTS);

  // Frame state
  logic [15:0]      gap_q;
  logic [31:0]      last_time_q;
  logic [POS_W-1:0] pos_q;
  logic [7:0]       sync_q;
  logic             older_q;
  logic [5:0]       len_q;
  logic [1:0]       off_q;

  // Checksum and payload
  logic [15:0]      acc_q;
  logic [7:0]       hold_q;
  logic [7:0]       lo_q;
  logic [31:0]      time_q;
  logic [VAL_W-1:0] slot_mem [ibfr_pkg::SLOT_DEPTH];
  logic [VAL_W-1:0] ext_q [ibfr_pkg::MAX_EXTRA];
  logic [VAL_W-1:0] rd_q;
  logic [CH_W-1:0]  ch_q;

  // Byte intake
  logic [31:0]      diff;
  logic             gap;
  logic [POS_W-1:0] pos_eff;
  logic [5:0]       pos_ext;
  logic             at_start, is_new, is_old, sync_ok, take, relatch;
  logic [7:0]       sync_n;
  logic             older_n;
  logic [5:0]       len_n;
  logic [1:0]       off_n;
  logic             complete;
  logic [POS_W-1:0] rel;
  logic             in_data, hi;
  logic [SLOT_AW-1:0] slot;
  logic             sum_new, sum_old;
  logic [15:0]      addend, got;
  logic             good;
  ibfr_pkg::ext_place_t place;

  assign diff     = now_us_i - last_time_q;
  // a negative signed difference never counts as a gap
  assign gap      = !diff[31] && (diff > {16'd0, gap_q});
  assign pos_eff  = gap ? '0 : pos_q;
  assign pos_ext  = {1'b0, pos_eff};
  assign at_start = (pos_eff == '0);
  assign is_new   = (rx_byte_i == ibfr_pkg::LEN_SHORT) || (rx_byte_i == ibfr_pkg::LEN_NEW);
  assign is_old   = (sync_q == 8'd0) && (rx_byte_i == ibfr_pkg::SYNC_OLD);
  assign sync_ok  = (sync_q != 8'd0) && (sync_q == rx_byte_i);
  assign take     = !at_start || is_new || is_old || sync_ok;
  assign relatch  = at_start && (is_new || is_old);

  always_comb begin
    sync_n  = sync_q;
    older_n = older_q;
    len_n   = len_q;
    off_n   = off_q;
    if (at_start && is_new) begin
      sync_n  = rx_byte_i;
      older_n = 1'b0;
      len_n   = rx_byte_i[5:0];
      off_n   = ibfr_pkg::OFF_NEW;
    end else if (at_start && is_old) begin
      sync_n  = ibfr_pkg::SYNC_OLD;
      older_n = 1'b1;
      len_n   = ibfr_pkg::LEN_OLD;
      off_n   = ibfr_pkg::OFF_OLD;
    end
  end

  assign complete = (len_n != 6'd0) && ((pos_ext + 6'd1) == len_n);
  assign rel      = pos_eff - {{(POS_W-2){1'b0}}, off_n};
  assign in_data  = (pos_eff >= {{(POS_W-2){1'b0}}, off_n}) && (rel < DATA_BYTES);
  assign hi       = rel[0];
  assign slot     = rel[SLOT_AW:1];
  assign place    = ibfr_pkg::ext_place(slot);

  // newer format sums every byte before the checksum; older sums slot words
  assign sum_new = !older_n && ((pos_ext + 6'd2) < len_n);
  assign sum_old = older_n && in_data;
  always_comb begin
    addend = 16'd0;
    if (sum_new) begin
      addend = {8'd0, rx_byte_i};
    end else if (sum_old) begin
      addend = hi ? {rx_byte_i, 8'd0} : {8'd0, rx_byte_i};
    end
  end

  assign got  = {rx_byte_i, hold_q};
  assign good = older_n ? (acc_q == got) : (~acc_q == got);

  assign status_o.frame_emit = take && complete && good &&
                               (older_n || (sync_n == ibfr_pkg::LEN_NEW));
  assign status_o.ch_last    = (ch_q == LAST_CH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q       <= ibfr_pkg::GAP_RESET;
      last_time_q <= '0;
      pos_q       <= '0;
      sync_q      <= '0;
      older_q     <= 1'b0;
      len_q       <= '0;
      off_q       <= '0;
    end else begin
      if (cfg_we_i) gap_q <= cfg_wdata_i;
      if (cmd_i.take_byte) begin
        last_time_q <= now_us_i;
        if (!take) begin
          pos_q <= pos_eff;
        end else begin
          pos_q <= complete ? pos_eff : pos_eff + POS_W'(1);
          if (relatch) begin
            sync_q  <= sync_n;
            older_q <= older_n;
            len_q   <= len_n;
            off_q   <= off_n;
          end
        end
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && take) begin
      acc_q <= (at_start ? 16'd0 : acc_q) + addend;
      if ((pos_ext + 6'd2) == len_n) hold_q <= rx_byte_i;
      if (in_data && !hi) lo_q <= rx_byte_i;
      if (in_data && hi && place.hit) begin
        case (place.part)
          2'd0:    ext_q[place.grp][3:0]  <= rx_byte_i[7:4];
          2'd1:    ext_q[place.grp][7:4]  <= rx_byte_i[7:4];
          default: ext_q[place.grp][11:8] <= rx_byte_i[7:4];
        endcase
      end
      if (status_o.frame_emit) time_q <= now_us_i;
    end
  end

  // Slot word memory: one write on each slot high byte, one registered read
  logic [CH_W-1:0] rd_addr;
  assign rd_addr = cmd_i.step ? ch_q + CH_W'(1) : (cmd_i.load ? '0 : ch_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte && take && in_data && hi) begin
      slot_mem[slot] <= {rx_byte_i[3:0], lo_q};
    end
    if (rd_addr < SLOT_CH) begin
      rd_q <= slot_mem[rd_addr[SLOT_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (cmd_i.load) begin
      ch_q <= '0;
    end else if (cmd_i.step) begin
      ch_q <= ch_q + CH_W'(1);
    end
  end

  logic [CH_W-1:0] ext_off;
  assign ext_off = ch_q - SLOT_CH;

  assign channel_index_o = ch_q;
  assign channel_value_o = (ch_q < SLOT_CH) ? rd_q : ext_q[ext_off[ibfr_pkg::EXT_AW-1:0]];
  assign frame_time_us_o = time_q;
  assign last_o          = (ch_q == LAST_CH);

endmodule

`default_nettype wire

// ----- sv/ibus_frame_receiver.sv -----
// Flow: after the final byte of a good 31/32-byte frame the controller passes through its
//   load state, then channels go out one per cycle while out_ready_i is high.
// Intake: in_ready_o stays low after a good frame through the load state (slot memory
//   read) and the emission of every channel, also while out_ready_i is low.
// Reset: rst_ni async low; frame state cleared, no sync latched, gap threshold 500 us.
// Top level of the serial RC frame receiver; depends on ibfr_pkg, ibfr_ctrl, ibfr_datapath.
`default_nettype none

module ibus_frame_receiver #(
  parameter int NUM_CHANNELS = 18
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // gap threshold register
  input  wire logic                           cfg_we_i,
  input  wire logic [15:0]                    cfg_wdata_i,
  // byte channel
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [7:0]                     rx_byte_i,
  input  wire logic [31:0]                    now_us_i,
  // channel result channel
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [ibfr_pkg::CH_W-1:0]           channel_index_o,
  output logic [ibfr_pkg::VAL_W-1:0]          channel_value_o,
  output logic [31:0]                         frame_time_us_o,
  output logic                                last_o
);

  // Controller sequences intake and emission; datapath holds all frame state,
  // the running checksum (checked on the final byte without a buffer pass) and
  // the slot word memory that is read out one channel per transaction.
  ibfr_pkg::cmd_t    cmd;
  ibfr_pkg::status_t status;

  ibfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ibfr_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_byte_i       (rx_byte_i),
    .now_us_i        (now_us_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .frame_time_us_o (frame_time_us_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for ibus_frame_receiver: byte stream in, decoded channels out.
// Depends on ibfr_pkg and the ibus_frame_receiver RTL; it needs no files or arguments.

module testbench;

  localparam int NUM_CHANNELS = 18;
  localparam int HOLD_CYCLES  = 400;               // long receiver hold-off
  localparam int SETTLE       = NUM_CHANNELS + 4;  // quiet cycles before a register write
  localparam int STALL_LIMIT  = 3000;              // cycles with no transaction at all

  typedef enum int {FMT_OLD, FMT_NEW32, FMT_NEW4} frame_fmt_e;

  // One decoded channel as it appears on the result port
  typedef struct packed {
    logic [ibfr_pkg::CH_W-1:0]  index;
    logic [ibfr_pkg::VAL_W-1:0] value;
    logic [31:0]                stamp;
    logic                       last;
  } channel_t;

  // Frame tracker: follows the receiver's frame state byte by byte and keeps the
  // channels that a good frame must produce, oldest first.
  class frame_tracker;
    logic [15:0] gap_us;
    logic [31:0] prev_time;
    logic [4:0]  pos;
    logic [7:0]  sync;
    bit          older;
    logic [5:0]  flen;
    logic [1:0]  offset;
    logic [7:0]  frame_mem [ibfr_pkg::BUFFER_BYTES];
    channel_t    channels_due [$];
    int          faults;
    int          frames_out;
    int          checked;

    function new();
      gap_us     = ibfr_pkg::GAP_RESET;
      prev_time  = '0;
      pos        = '0;
      sync       = '0;
      older      = 1'b0;
      flen       = '0;
      offset     = '0;
      faults     = 0;
      frames_out = 0;
      checked    = 0;
      foreach (frame_mem[i]) frame_mem[i] = '0;
    endfunction

    // little-endian word at byte o
    function logic [15:0] word_at(int o);
      return {frame_mem[(o + 1) % ibfr_pkg::BUFFER_BYTES],
              frame_mem[o % ibfr_pkg::BUFFER_BYTES]};
    endfunction

    function bit checksum_ok();
      logic [15:0] sum;
      logic [15:0] got;
      int i;
      sum = '0;
      got = word_at(int'(flen) - 2);
      if (older) begin
        for (i = 0; i < ibfr_pkg::NUM_SLOTS; i++) sum += word_at(int'(offset) + 2 * i);
        return sum == got;
      end
      for (i = 0; i + 2 < int'(flen); i++) sum += 16'(frame_mem[i]);
      return (16'hFFFF - sum) == got;
    endfunction

    // slot channels: low 12 bits of the slot word; extra channels: upper nibbles
    function logic [ibfr_pkg::VAL_W-1:0] channel_value(int ch);
      int o;
      logic [15:0] w;
      if (ch < ibfr_pkg::NUM_SLOTS) begin
        w = word_at(int'(offset) + 2 * ch);
        return w[11:0];
      end
      o = int'(offset) + 1 + 6 * (ch - ibfr_pkg::NUM_SLOTS);
      return {frame_mem[o + 4][7:4], frame_mem[o + 2][7:4], frame_mem[o][7:4]};
    endfunction

    // note one accepted byte transaction
    function void take_byte(logic [7:0] b, logic [31:0] t);
      logic [31:0] diff;
      channel_t c;
      int ch;
      diff = t - prev_time;
      // a negative difference never restarts the frame
      if (!diff[31] && diff > {16'd0, gap_us}) pos = '0;
      prev_time = t;
      if (pos == 0) begin
        if (b == ibfr_pkg::LEN_SHORT || b == ibfr_pkg::LEN_NEW) begin
          older  = 1'b0;
          sync   = b;
          flen   = b[5:0];
          offset = ibfr_pkg::OFF_NEW;
        end else if (sync == 0 && b == ibfr_pkg::SYNC_OLD) begin
          older  = 1'b1;
          sync   = ibfr_pkg::SYNC_OLD;
          flen   = ibfr_pkg::LEN_OLD;
          offset = ibfr_pkg::OFF_OLD;
        end else if (sync == 0 || sync != b) begin
          return;
        end
      end
      frame_mem[pos] = b;
      // position sticks on the final byte until the next gap
      if (flen == 0 || int'(pos) + 1 != int'(flen)) begin
        pos = pos + 5'd1;
        return;
      end
      if (!checksum_ok() || !(older || sync == ibfr_pkg::LEN_NEW)) return;
      frames_out++;
      for (ch = 0; ch < NUM_CHANNELS; ch++) begin
        c.index = ibfr_pkg::CH_W'(ch);
        c.value = channel_value(ch);
        c.stamp = t;
        c.last  = (ch == NUM_CHANNELS - 1);
        channels_due.push_back(c);
      end
    endfunction

    task flag(string what);
      $display("ERROR @%0t: %s", $time, what);
      faults++;
    endtask

    // compare one result transaction with the oldest channel due
    task match_channel(channel_t got);
      channel_t want;
      if (channels_due.size() == 0) begin
        flag($sformatf("channel %0d arrived with none outstanding", got.index));
        return;
      end
      want = channels_due.pop_front();
      checked++;
      if (got.index !== want.index)
        flag($sformatf("channel_index %0d, wanted %0d", got.index, want.index));
      if (got.value !== want.value)
        flag($sformatf("ch %0d channel_value %h, wanted %h", want.index, got.value, want.value));
      if (got.stamp !== want.stamp)
        flag($sformatf("ch %0d frame_time_us %h, wanted %h", want.index, got.stamp, want.stamp));
      if (got.last !== want.last)
        flag($sformatf("ch %0d last %b, wanted %b", want.index, got.last, want.last));
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [15:0]                cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [7:0]                 rx_byte_i;
  logic [31:0]                now_us_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [ibfr_pkg::CH_W-1:0]  channel_index_o;
  logic [ibfr_pkg::VAL_W-1:0] channel_value_o;
  logic [31:0]                frame_time_us_o;
  logic                       last_o;

  frame_tracker tracker;
  channel_t     seen;
  logic [31:0]  clock_us;     // timestamp source for the byte stream
  logic [15:0]  gap_us;       // stimulus copy of the gap threshold
  logic [7:0]   frame_q [$];  // bytes of the frame being sent
  bit           hold_req;     // asks the receiver for one long hold-off
  bit           tx_burst;
  bit           rx_burst;
  int           frame_items;
  int           frames_sent;
  int           holds_done;
  int           quiet;

  ibus_frame_receiver #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .now_us_i       (now_us_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .channel_index_o(channel_index_o),
    .channel_value_o(channel_value_o),
    .frame_time_us_o(frame_time_us_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Monitor. Everything is sampled at the rising edge, before the drivers'
  // nonblocking updates land, so the tracker sees what the block sees.
  always @(posedge clk_i) begin
    if (cfg_we_i) tracker.gap_us = cfg_wdata_i;
    if (in_valid_i && in_ready_o) tracker.take_byte(rx_byte_i, now_us_i);
    if (out_valid_o && out_ready_i) begin
      seen.index = channel_index_o;
      seen.value = channel_value_o;
      seen.stamp = frame_time_us_o;
      seen.last  = last_o;
      tracker.match_channel(seen);
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: random stalls per transaction, runs of zero stall, and one
  // long hold-off on request so that the block backs up into its input.
  initial begin : rx_side
    int idle;
    out_ready_i = 1'b0;
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        holds_done++;
      end
      idle = rx_burst ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      if (idle > 0) begin
        out_ready_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Timestamp for the next byte. A restart lands past the gap; inside a frame
  // the step stays within the gap, sometimes exactly on it, sometimes negative,
  // and now and then jumps by half the counter range (negative as signed).
  function automatic logic [31:0] advance(input bit restart);
    int pick;
    pick = $urandom_range(0, 63);
    if (restart)
      clock_us = clock_us + gap_us + 32'd1 + (pick == 0 ? 32'd0 : $urandom_range(0, 3000));
    else if (pick == 0)
      clock_us = clock_us + 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
    else if (pick < 4)
      clock_us = clock_us - $urandom_range(1, 100000);
    else if (pick < 6)
      clock_us = clock_us + gap_us;
    else
      clock_us = clock_us + $urandom_range(0, gap_us);
    return clock_us;
  endfunction

  function automatic logic [7:0] data_byte(input bit extreme);
    int pick;
    pick = $urandom_range(0, 15);
    if (extreme || pick < 2) return pick[0] ? 8'hFF : 8'h00;
    return 8'($urandom);
  endfunction

  // Fill frame_q with a well-formed frame; bad_sum flips one bit after the sync.
  function automatic void build_frame(input frame_fmt_e fmt, input bit bad_sum,
                                      input bit extreme);
    int len;
    int i;
    int spot;
    logic [15:0] sum;
    frame_q.delete();
    case (fmt)
      FMT_OLD: begin
        len = ibfr_pkg::LEN_OLD;
        frame_q.push_back(ibfr_pkg::SYNC_OLD);
      end
      FMT_NEW32: begin
        len = ibfr_pkg::LEN_NEW;
        frame_q.push_back(ibfr_pkg::LEN_NEW);
      end
      default: begin
        len = ibfr_pkg::LEN_SHORT;
        frame_q.push_back(ibfr_pkg::LEN_SHORT);
      end
    endcase
    for (i = 1; i < len - 2; i++) frame_q.push_back(data_byte(extreme));
    sum = '0;
    if (fmt == FMT_OLD) begin
      for (i = 0; i < ibfr_pkg::NUM_SLOTS; i++)
        sum += {frame_q[ibfr_pkg::OFF_OLD + 2 * i + 1], frame_q[ibfr_pkg::OFF_OLD + 2 * i]};
    end else begin
      for (i = 0; i < len - 2; i++) sum += 16'(frame_q[i]);
      sum = 16'hFFFF - sum;
    end
    frame_q.push_back(sum[7:0]);
    frame_q.push_back(sum[15:8]);
    if (bad_sum) begin
      spot = $urandom_range(1, len - 1);
      frame_q[spot] = frame_q[spot] ^ (8'h01 << $urandom_range(0, 7));
    end
  endfunction

  // One byte transaction. Valid stays high across back-to-back bytes.
  task automatic send_byte(input logic [7:0] b, input bit restart);
    int idle;
    idle = tx_burst ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    if (idle > 0) begin
      in_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    now_us_i   <= advance(restart);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // cut_at > 0 breaks the frame there: with resync a gap restarts mid-frame and
  // the rest follows, otherwise the frame is just truncated. The first extra
  // byte repeats the final byte (frame emitted again), later ones are random.
  task automatic send_frame(input frame_fmt_e fmt, input bit bad_sum, input bit extreme,
                            input int cut_at, input bit resync, input int extra);
    int i;
    logic [7:0] tail;
    build_frame(fmt, bad_sum, extreme);
    frames_sent++;
    for (i = 0; i < frame_q.size(); i++) begin
      if (cut_at > 0 && i == cut_at && !resync) break;
      send_byte(frame_q[i], i == 0 || i == cut_at);
      frame_items++;
    end
    tail = frame_q[frame_q.size() - 1];
    for (i = 0; i < extra; i++) begin
      send_byte(i == 0 ? tail : 8'($urandom), 1'b0);
      frame_items++;
    end
  endtask

  // Stray bytes; while the older format is latched, length bytes are avoided
  // so that the format does not switch early.
  task automatic send_noise(input bit old_phase);
    logic [7:0] b;
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      b = 8'($urandom);
      if (old_phase && (b == ibfr_pkg::LEN_SHORT || b == ibfr_pkg::LEN_NEW)) b = b + 8'd1;
      send_byte(b, 1'($urandom_range(0, 1)));
    end
  endtask

  // Mostly good frames with random content, the rest broken or noise.
  task automatic random_frames(input bit old_phase, input int goal);
    int stop_at;
    int pick;
    frame_fmt_e main_fmt;
    main_fmt = old_phase ? FMT_OLD : FMT_NEW32;
    stop_at  = frame_items + goal;
    while (frame_items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        send_frame(main_fmt, 0, 0, 0, 0,
                   ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
      else if (pick < 60)
        send_frame(main_fmt, 1, 0, 0, 0, 0);
      else if (pick < 70)
        send_frame(main_fmt, 0, 0, $urandom_range(1, old_phase ? 30 : 31), !old_phase, 0);
      else if (pick < 80 && !old_phase)
        send_frame(FMT_NEW4, 1'($urandom_range(0, 1)), 0, 0, 0, $urandom_range(0, 1));
      else if (pick < 90)
        send_noise(old_phase);
      else
        send_frame(main_fmt, 0, 0, 0, 0, $urandom_range(1, 3));
    end
  endtask

  // Idle the input, wait for every due channel, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.channels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_gap(input logic [15:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    gap_us = v;
  endtask

  initial begin
    tracker     = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    rx_byte_i   = '0;
    now_us_i    = '0;
    hold_req    = 1'b0;
    gap_us      = ibfr_pkg::GAP_RESET;
    clock_us    = 32'hFFFF_F000;  // first frames cross the counter wrap
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bytes before any sync are dropped (zero byte, stray byte),
    // the older format is only reachable while nothing is latched.
    send_byte(8'h00, 1'b1);
    send_byte(8'hA7, 1'b1);
    send_frame(FMT_OLD, 0, 1, 0, 0, 2);   // extreme slots, re-emit, overwrite
    send_frame(FMT_OLD, 1, 0, 0, 0, 0);   // bad checksum

    // Older format at the reset gap, then at the widest gap.
    random_frames(1'b1, 24);
    drain();
    write_gap(16'hFFFF);
    random_frames(1'b1, 24);

    // Zero gap: every positive step restarts; switch to the newer format.
    drain();
    write_gap(16'h0000);
    send_frame(FMT_NEW4, 0, 0, 0, 0, 0);  // short frame, never emitted
    send_frame(FMT_NEW4, 1, 0, 0, 0, 0);
    send_byte(ibfr_pkg::SYNC_OLD, 1'b1);  // foreign first byte once synced
    send_frame(FMT_NEW32, 0, 1, 0, 0, 1);
    random_frames(1'b0, 24);

    // Random gap with one long receiver hold-off while frames keep coming.
    drain();
    write_gap(16'($urandom_range(1, 65534)));
    hold_req = 1'b1;
    send_frame(FMT_NEW32, 0, 0, 0, 0, 0);
    send_frame(FMT_NEW32, 0, 0, 0, 0, 0);
    random_frames(1'b0, 24);

    drain();
    write_gap(16'($urandom_range(1, 2000)));
    random_frames(1'b0, 24);
    drain();

    $display("Covered %0d frame bytes in %0d frames; %0d good frames, %0d channels checked.",
             frame_items, frames_sent, tracker.frames_out, tracker.checked);
    $display("Both frame formats, five gap settings, %0d long receiver hold-off(s).",
             holds_done);
    if (tracker.faults == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
